@@ sv/olt_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered list table package
// Field widths, operation and status codes, and parameter defaults shared by
// the ordered list table and its channel interfaces.
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WHERE_W  = 5;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

@@ sv/olt_req_if.sv @@
// ----------------------------------------------------------------------------
// Ordered list table request channel
// Valid/ready channel that carries one operation item into the table.
// ----------------------------------------------------------------------------
interface olt_req_if;
  import olt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, output func, output value, output position, input ready);
  modport sink (input valid, input func, input value, input position, output ready);
endinterface

@@ sv/olt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Ordered list table result channel
// Valid/ready channel that carries one result item out of the table.
// ----------------------------------------------------------------------------
interface olt_rsp_if;
  import olt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] read_value;
  logic [WHERE_W-1:0]        where_placed;
  logic [COUNT_W-1:0]        entry_count;

  modport source (
    output valid, output status, output read_value, output where_placed,
    output entry_count, input ready
  );
  modport sink (
    input valid, input status, input read_value, input where_placed,
    input entry_count, output ready
  );
endinterface

@@ sv/olt_ram.sv @@
// ----------------------------------------------------------------------------
// Ordered list table RAM
// Generic memory with one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module olt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/ordered_list_table.sv @@
// ----------------------------------------------------------------------------
// Ordered list table
// Full, range, clear and unused items go from accept straight to the done
// state; append passes the write state and read the read wait state first.
// Delete shifts any later entries down; insert scans for the first greater
// entry, shifts the later entries up and writes, one entry per cycle through
// the single RAM read port. One item is in work at a time, so the next item
// is taken only after the result is loaded. Reset empties the list.
// ----------------------------------------------------------------------------
module ordered_list_table #(
  parameter int unsigned CAPACITY   = olt_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = olt_pkg::DATA_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  olt_req_if.sink   in_i,
  olt_rsp_if.source out_o
);
  import olt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CW > WHERE_W) ? CW : WHERE_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHUP   = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_SHDN   = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [DATA_WIDTH-1:0] val_q;
  logic [IW-1:0]         pos_q;
  logic [IW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         slot_q, slot_d;
  logic [IW-1:0]         cnt_q, cnt_d;
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [VALUE_W-1:0]    res_read_q, res_read_d;
  logic [WHERE_W-1:0]    res_where_q, res_where_d;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q;
  logic [VALUE_W-1:0]    out_read_q;
  logic [WHERE_W-1:0]    out_where_q;
  logic [COUNT_W-1:0]    out_count_q;
  logic                  out_load;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                     accept;
  logic [IW-1:0]            in_pos, in_pos_p1;
  logic [IW-1:0]            idx_p1, idx_p2, idx_m1, idx_m2, cnt_m1;
  logic [DATA_WIDTH+31:0]   val_wide;
  logic [DATA_WIDTH+31:0]   rd_wide;
  logic                     greater;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign in_pos     = IW'(in_i.position);
  assign in_pos_p1  = in_pos + IW'(1);
  assign idx_p1     = idx_q + IW'(1);
  assign idx_p2     = idx_q + IW'(2);
  assign idx_m1     = idx_q - IW'(1);
  assign idx_m2     = idx_q - IW'(2);
  assign cnt_m1     = cnt_q - IW'(1);
  assign val_wide   = {{DATA_WIDTH{in_i.value[VALUE_W-1]}}, in_i.value};
  assign rd_wide    = {32'b0, ram_rdata};
  assign greater    = $signed(ram_rdata) > $signed(val_q);

  olt_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_read_d   = res_read_q;
    res_where_d  = res_where_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = '0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_DONE;
          res_read_d   = '0;
          res_where_d  = '0;
          state_d      = S_DONE;
          unique case (in_i.func) inside
            FUNC_APPEND, FUNC_INSERT: begin
              if (cnt_q >= IW'(CAPACITY)) begin
                res_status_d = ST_FULL;
              end else if (in_i.func == FUNC_APPEND || cnt_q == '0) begin
                slot_d  = cnt_q;
                state_d = S_WRITE;
              end else begin
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            FUNC_DELETE: begin
              if (in_pos >= cnt_q) begin
                res_status_d = ST_RANGE;
              end else if (in_pos_p1 < cnt_q) begin
                idx_d     = in_pos;
                ram_raddr = in_pos_p1[AW-1:0];
                state_d   = S_SHDN;
              end else begin
                cnt_d       = cnt_m1;
                res_where_d = in_pos[WHERE_W-1:0];
              end
            end
            FUNC_READ: begin
              if (in_pos >= cnt_q) begin
                res_status_d = ST_RANGE;
              end else begin
                ram_raddr = in_pos[AW-1:0];
                state_d   = S_RDWAIT;
              end
            end
            FUNC_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (greater) begin
          slot_d    = idx_q;
          idx_d     = cnt_q;
          ram_raddr = cnt_m1[AW-1:0];
          state_d   = S_SHUP;
        end else if (idx_p1 == cnt_q) begin
          slot_d  = cnt_q;
          state_d = S_WRITE;
        end else begin
          idx_d     = idx_p1;
          ram_raddr = idx_p1[AW-1:0];
        end
      end
      S_SHUP: begin
        ram_we = 1'b1;
        if (idx_m1 == slot_q) begin
          state_d = S_WRITE;
        end else begin
          idx_d     = idx_m1;
          ram_raddr = idx_m2[AW-1:0];
        end
      end
      S_WRITE: begin
        ram_we      = 1'b1;
        ram_waddr   = slot_q[AW-1:0];
        ram_wdata   = val_q;
        cnt_d       = cnt_q + IW'(1);
        res_where_d = slot_q[WHERE_W-1:0];
        state_d     = S_DONE;
      end
      S_SHDN: begin
        ram_we = 1'b1;
        if (idx_p2 >= cnt_q) begin
          cnt_d       = cnt_m1;
          res_where_d = pos_q[WHERE_W-1:0];
          state_d     = S_DONE;
        end else begin
          idx_d     = idx_p1;
          ram_raddr = idx_p2[AW-1:0];
        end
      end
      S_RDWAIT: begin
        res_read_d  = rd_wide[VALUE_W-1:0];
        res_where_d = pos_q[WHERE_W-1:0];
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_read_q   <= res_read_d;
    res_where_q  <= res_where_d;
    if (accept) begin
      val_q <= val_wide[DATA_WIDTH-1:0];
      pos_q <= in_pos;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_read_q   <= res_read_q;
      out_where_q  <= res_where_q;
      out_count_q  <= cnt_q[COUNT_W-1:0];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.read_value   = out_read_q;
  assign out_o.where_placed = out_where_q;
  assign out_o.entry_count  = out_count_q;

endmodule

@@ test/ordered_list_table_checker.sv @@
// ----------------------------------------------------------------------------
// Ordered list table checker
// Watches the request and result channels of the ordered list table, keeps
// its own copy of the list, works out the result of every accepted item and
// compares each accepted result, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_table_checker (
  input  logic clk_i,
  input  logic rst_ni,
  olt_req_if   req_i,
  olt_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  import olt_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
    logic [WHERE_W-1:0]        where_placed;
    logic [COUNT_W-1:0]        entry_count;
  } list_result_t;

  list_result_t              result_q[$];
  logic signed [VALUE_W-1:0] list_entries[CAPACITY_DEF];
  int                        list_count;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ordered_list_table_checker: %s got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic list_result_t apply_operation(
    input logic [FUNC_W-1:0]         func,
    input logic signed [VALUE_W-1:0] value,
    input logic [POS_W-1:0]          position
  );
    list_result_t res;
    int           slot;
    int           i;
    res = '0;
    case (func)
      FUNC_APPEND, FUNC_INSERT: begin
        if (list_count >= CAPACITY_DEF) begin
          res.status = ST_FULL;
        end else begin
          slot = list_count;
          if (func == FUNC_INSERT) begin
            // The first entry strictly greater wins, so equal values keep arrival order.
            for (i = 0; i < list_count; i++) begin
              if (list_entries[i] > value) begin
                slot = i;
                break;
              end
            end
          end
          for (i = list_count; i > slot; i--) begin
            list_entries[i] = list_entries[i-1];
          end
          list_entries[slot] = value;
          list_count++;
          res.where_placed = WHERE_W'(slot);
        end
      end
      FUNC_DELETE: begin
        if (int'(position) >= list_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = int'(position); i + 1 < list_count; i++) begin
            list_entries[i] = list_entries[i+1];
          end
          list_count--;
          res.where_placed = WHERE_W'(position);
        end
      end
      FUNC_READ: begin
        if (int'(position) >= list_count) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value   = list_entries[position];
          res.where_placed = WHERE_W'(position);
        end
      end
      FUNC_CLEAR: begin
        list_count = 0;
      end
      default: begin
      end
    endcase
    res.entry_count = COUNT_W'(list_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      result_q.delete();
      list_count   = 0;
      fail_count_o = 0;
      pending_o    <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with none expected, status", rsp_i.status, 0);
        end else begin
          want = result_q.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch("status", rsp_i.status, want.status);
          if (rsp_i.read_value !== want.read_value)
            report_mismatch("read_value", rsp_i.read_value, want.read_value);
          if (rsp_i.where_placed !== want.where_placed)
            report_mismatch("where_placed", rsp_i.where_placed, want.where_placed);
          if (rsp_i.entry_count !== want.entry_count)
            report_mismatch("entry_count", rsp_i.entry_count, want.entry_count);
        end
      end
      if (req_i.valid && req_i.ready) begin
        result_q.push_back(apply_operation(req_i.func, req_i.value, req_i.position));
      end
      pending_o <= result_q.size();
    end
  end

endmodule

@@ test/ordered_list_table_tb.sv @@
// ----------------------------------------------------------------------------
// Ordered list table testbench
// Drives a short directed sequence and then phases of random operations into
// the ordered list table, with random gaps on both channels and a full drain
// between phases. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_table_tb;
  import olt_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_MID   = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;
  localparam int                STALL_LIMIT       = 2000;
  localparam int                PHASE_COUNT       = 8;
  localparam int                PHASE_ITEMS       = 160;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fffffff;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh80000000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   stall_cycles;
  bit   idle_on;
  int   list_size;

  olt_req_if req_if ();
  olt_rsp_if rsp_if ();

  ordered_list_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  ordered_list_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    return idle_on ? int'($urandom_range(0, 10)) : 0;
  endfunction

  // Keeps track of the list size only to steer positions into range.
  task automatic send_item(
    input logic [FUNC_W-1:0]         func,
    input logic signed [VALUE_W-1:0] value,
    input logic [POS_W-1:0]          position
  );
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.func     = func;
    req_if.value    = value;
    req_if.position = position;
    req_if.valid    = 1'b1;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    case (func)
      FUNC_APPEND, FUNC_INSERT: if (list_size < CAPACITY_DEF) list_size++;
      FUNC_DELETE: if (int'(position) < list_size) list_size--;
      FUNC_CLEAR: list_size = 0;
      default: begin
      end
    endcase
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int grow_pct);
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    int                        roll;
    roll = $urandom_range(0, 99);
    if (roll < grow_pct) begin
      func = ($urandom_range(0, 2) == 0) ? FUNC_APPEND : FUNC_INSERT;
    end else if (roll < 95) begin
      func = ($urandom_range(0, 1) == 0) ? FUNC_DELETE : FUNC_READ;
    end else if (roll < 97) begin
      func = FUNC_CLEAR;
    end else begin
      func = FUNC_W'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
    end
    case ($urandom_range(0, 3))
      0: value = int'($urandom_range(0, 8)) - 4;
      1: value = ($urandom_range(0, 1) == 0) ? VALUE_MIN : VALUE_MAX;
      default: value = $urandom;
    endcase
    if (list_size > 0 && $urandom_range(0, 99) < 85) begin
      position = POS_W'($urandom_range(0, list_size - 1));
    end else begin
      position = POS_W'($urandom_range(0, CAPACITY_DEF - 1));
    end
    send_item(func, value, position);
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int gap;
      gap = draw_gap();
      @(negedge clk_i);
      if (gap != 0) begin
        rsp_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("ordered_list_table_tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.func     = FUNC_APPEND;
    req_if.value    = '0;
    req_if.position = '0;
    idle_on         = 1'b1;
    list_size       = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(FUNC_READ, 0, 0);
    send_item(FUNC_DELETE, 0, 0);
    send_item(FUNC_UNUSED_FIRST, 0, 0);
    send_item(FUNC_UNUSED_MID, -1, 4'd9);
    send_item(FUNC_UNUSED_LAST, VALUE_MAX, 4'd15);
    send_item(FUNC_APPEND, VALUE_MAX, 0);
    send_item(FUNC_APPEND, VALUE_MIN, 0);
    send_item(FUNC_INSERT, 0, 0);
    send_item(FUNC_INSERT, 0, 0);
    send_item(FUNC_INSERT, -1, 0);
    send_item(FUNC_INSERT, VALUE_MAX, 0);
    send_item(FUNC_INSERT, VALUE_MIN, 0);
    send_item(FUNC_READ, 0, 0);
    send_item(FUNC_READ, 0, 4'd6);
    send_item(FUNC_READ, 0, 4'd15);
    send_item(FUNC_DELETE, 0, POS_W'(list_size - 1));
    send_item(FUNC_DELETE, 0, 0);
    send_item(FUNC_READ, 0, 0);
    send_item(FUNC_CLEAR, 0, 0);
    send_item(FUNC_READ, 0, 0);
    send_item(FUNC_APPEND, -5, 0);
    send_item(FUNC_INSERT, 3, 0);
    wait_for_results();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      idle_on = (phase % 3 != 2);
      repeat (PHASE_ITEMS) send_random((phase % 2 == 0) ? 70 : 35);
      wait_for_results();
    end

    repeat (2 * CAPACITY_DEF + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ordered_list_table_tb: clean");
    end else begin
      $display("ordered_list_table_tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/olt_pkg.sv
sv/olt_req_if.sv
sv/olt_rsp_if.sv
sv/olt_ram.sv
sv/ordered_list_table.sv
test/ordered_list_table_checker.sv
test/ordered_list_table_tb.sv
